@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked on every rising clk edge out of reset
`define RBR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbr assertion failed");
// next-cycle implication
`define RBR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbr assertion failed");
`else
`define RBR_ASSERT_IMP(label, ante, cons)
`define RBR_ASSERT_NXT(label, ante, cons)
`endif
`endif

@@ rtl/rbr_pkg.sv @@
// shared widths, opcodes and controller/datapath structs
package rbr_pkg;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 32;
  localparam int SLOPE_W = 17;
  localparam int ENTRY_W = 16;
  localparam int TCNT_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_RELAX  = 2'd0,
    OP_PRESET = 2'd1,
    OP_SUBST  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;    // latch word, issue memory reads
    logic dispatch;  // divider init and slope products
    logic div_step;  // one quotient bit
    logic mul_icp;   // intercept products
    logic finish;    // load result, write state
  } rbr_cmd_t;

  typedef struct packed {
    op_t  op;
    logic unfixed;
  } rbr_stat_t;
endpackage

@@ rtl/rbr_if.sv @@
// handshake channels for input and result words
interface rbr_in_if import rbr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        neuron;
  logic [IDX_W-1:0]        source_neuron;
  logic [IDX_W-1:0]        target;
  logic signed [VAL_W-1:0] lower_value;
  logic signed [VAL_W-1:0] upper_value;
  modport source (output valid, op, neuron, source_neuron, target, lower_value,
                  upper_value, input ready);
  modport sink (input valid, op, neuron, source_neuron, target, lower_value,
                upper_value, output ready);
endinterface

interface rbr_out_if import rbr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] concrete_lower;
  logic signed [VAL_W-1:0] concrete_upper;
  logic [SLOPE_W-1:0]      lower_slope;
  logic [SLOPE_W-1:0]      upper_slope;
  logic signed [VAL_W-1:0] upper_intercept;
  logic [ENTRY_W-1:0]      entry_index;
  logic signed [VAL_W-1:0] lower_term;
  logic signed [VAL_W-1:0] upper_term;
  logic signed [VAL_W-1:0] lower_bias_sum;
  logic signed [VAL_W-1:0] upper_bias_sum;
  modport source (output valid, concrete_lower, concrete_upper, lower_slope,
                  upper_slope, upper_intercept, entry_index, lower_term, upper_term,
                  lower_bias_sum, upper_bias_sum, input ready);
  modport sink (input valid, concrete_lower, concrete_upper, lower_slope,
                upper_slope, upper_intercept, entry_index, lower_term, upper_term,
                lower_bias_sum, upper_bias_sum, output ready);
endinterface

@@ rtl/rbr_ctrl.sv @@
// sequencing state machine for relax, preset and substitute words
module rbr_ctrl import rbr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  rbr_stat_t stat,
  output rbr_cmd_t  cmd
);
  localparam int CW = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_DIV, S_MUL_ICP, S_FIN
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  logic          slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.dispatch = (state_r == S_DISPATCH);
    cmd.div_step = (state_r == S_DIV);
    cmd.mul_icp  = (state_r == S_MUL_ICP);
    cmd.finish   = (state_r == S_FIN) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces the one draining in the same cycle
      if ((state_r == S_FIN) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          cnt_r <= '0;
          unique case (stat.op)
            OP_RELAX: state_r <= stat.unfixed ? S_DIV : S_FIN;
            OP_SUBST: state_r <= S_MUL_ICP;
            default:  state_r <= S_FIN;
          endcase
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(FRAC_BITS - 1)) begin
            state_r <= S_MUL_ICP;
          end
        end
        S_MUL_ICP: state_r <= S_FIN;
        S_FIN: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/rbr_dpath.sv @@
// operand registers, divider, multipliers, relaxation and bias memories
module rbr_dpath import rbr_pkg::*; #(
  parameter int NEURONS   = 256,
  parameter int TARGETS   = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rbr_cmd_t                cmd,
  output rbr_stat_t               stat,
  input  logic                    cfg_we,
  input  logic [TCNT_W-1:0]       cfg_wdata,
  input  logic [OP_W-1:0]         in_op,
  input  logic [IDX_W-1:0]        in_neuron,
  input  logic [IDX_W-1:0]        in_source_neuron,
  input  logic [IDX_W-1:0]        in_target,
  input  logic signed [VAL_W-1:0] in_lower_value,
  input  logic signed [VAL_W-1:0] in_upper_value,
  output logic signed [VAL_W-1:0] out_concrete_lower,
  output logic signed [VAL_W-1:0] out_concrete_upper,
  output logic [SLOPE_W-1:0]      out_lower_slope,
  output logic [SLOPE_W-1:0]      out_upper_slope,
  output logic signed [VAL_W-1:0] out_upper_intercept,
  output logic [ENTRY_W-1:0]      out_entry_index,
  output logic signed [VAL_W-1:0] out_lower_term,
  output logic signed [VAL_W-1:0] out_upper_term,
  output logic signed [VAL_W-1:0] out_lower_bias_sum,
  output logic signed [VAL_W-1:0] out_upper_bias_sum
);
  localparam int SW     = FRAC_BITS + 1;
  localparam int NDEPTH = (NEURONS < 256) ? NEURONS : 256;
  localparam int TDEPTH = (TARGETS < 256) ? TARGETS : 256;
  localparam int NAW    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int RW     = 1 + SW + VAL_W;
  localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;
  localparam logic signed [65:0] MAXV = 66'sd2147483647;
  localparam logic signed [65:0] MINV = -66'sd2147483648;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [65:0] v);
    if (v > MAXV) return 32'sh7FFFFFFF;
    if (v < MINV) return 32'sh80000000;
    return v[VAL_W-1:0];
  endfunction

  // operand registers
  op_t                     op_r;
  logic [IDX_W-1:0]        nrn_r, src_r, tgt_r;
  logic signed [VAL_W-1:0] lv_r, uv_r;
  logic [TCNT_W-1:0]       tcount_r;

  // memories
  logic [RW-1:0]        relax_mem [NDEPTH];
  logic [2*VAL_W-1:0]   bias_mem [TDEPTH];
  logic [TDEPTH-1:0]    bias_vld_r;
  logic [RW-1:0]        relax_rd_r;
  logic [2*VAL_W-1:0]   bias_rd_r;
  logic                 bias_rd_vld_r;

  // divider and products
  logic [32:0]             rem_r;
  logic [FRAC_BITS-1:0]    q_r;
  logic signed [64:0]      p_lo_slope_r, p_up_slope_r, p_lo_icp_r, p_up_icp_r;

  logic nrn_ok, tgt_ok, active, inactive;
  assign nrn_ok   = int'(nrn_r) < NEURONS;
  assign tgt_ok   = int'(tgt_r) < TARGETS;
  assign active   = !lv_r[VAL_W-1];
  assign inactive = !active && (uv_r <= 0);

  assign stat.op      = op_r;
  assign stat.unfixed = !active && !inactive;

  // relaxation read back, zero for out-of-range neurons
  logic                    rd_ls;
  logic [SW-1:0]           rd_us;
  logic signed [VAL_W-1:0] rd_icp;
  assign rd_ls  = nrn_ok & relax_rd_r[RW-1];
  assign rd_us  = nrn_ok ? relax_rd_r[VAL_W +: SW] : '0;
  assign rd_icp = nrn_ok ? relax_rd_r[VAL_W-1:0] : '0;

  // shared pair of multipliers
  logic signed [32:0] coef;
  logic signed [64:0] m_lo, m_up;
  always_comb begin
    if (cmd.mul_icp) begin
      coef = (op_r == OP_RELAX) ? $signed(33'(q_r)) : 33'(rd_icp);
    end else begin
      coef = $signed(33'(rd_us));
    end
  end
  assign m_lo = lv_r * coef;
  assign m_up = uv_r * coef;

  // one restoring division step
  logic signed [32:0] den;
  logic [33:0]        rem2;
  logic               q_bit;
  assign den   = 33'(uv_r) - 33'(lv_r);
  assign rem2  = {rem_r, 1'b0};
  assign q_bit = rem2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcount_r <= TCNT_W'(256);
    end else if (cfg_we) begin
      tcount_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r          <= op_t'(in_op);
      nrn_r         <= in_neuron;
      src_r         <= in_source_neuron;
      tgt_r         <= in_target;
      lv_r          <= in_lower_value;
      uv_r          <= in_upper_value;
      relax_rd_r    <= relax_mem[in_neuron[NAW-1:0]];
      bias_rd_r     <= bias_mem[in_target[TAW-1:0]];
      bias_rd_vld_r <= bias_vld_r[in_target[TAW-1:0]];
    end
    if (cmd.dispatch) begin
      rem_r        <= {1'b0, uv_r};
      q_r          <= '0;
      p_lo_slope_r <= m_lo;
      p_up_slope_r <= m_up;
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? 33'(rem2 - {1'b0, den}) : rem2[32:0];
      q_r   <= {q_r[FRAC_BITS-2:0], q_bit};
    end
    if (cmd.mul_icp) begin
      p_lo_icp_r <= m_lo;
      p_up_icp_r <= m_up;
    end
  end

  // relax result
  logic                    rx_ls;
  logic [SW-1:0]           rx_us;
  logic signed [VAL_W-1:0] rx_icp, rx_clo, rx_cup;
  logic signed [65:0]      neg_p;
  logic signed [32:0]      lneg;
  assign neg_p = 66'sd0 - 66'(p_lo_icp_r);
  assign lneg  = 33'sd0 - 33'(lv_r);
  always_comb begin
    if (active) begin
      rx_ls = 1'b1; rx_us = ONE; rx_icp = '0; rx_clo = lv_r; rx_cup = uv_r;
    end else if (inactive) begin
      rx_ls = 1'b0; rx_us = '0; rx_icp = '0; rx_clo = '0; rx_cup = '0;
    end else begin
      rx_us  = SW'(q_r);
      rx_icp = sat32(neg_p >>> FRAC_BITS);
      rx_cup = uv_r;
      rx_ls  = 33'(uv_r) > lneg;
      rx_clo = rx_ls ? lv_r : '0;
    end
  end

  // substitute result
  logic signed [VAL_W-1:0] lterm, uterm, lbias, ubias, acc_lo, acc_up;
  logic signed [VAL_W-1:0] sum_lo, sum_up;
  logic [17:0]             entry;
  always_comb begin
    if (!lv_r[VAL_W-1]) begin
      lterm = rd_ls ? lv_r : '0;
      lbias = '0;
    end else begin
      lterm = sat32(66'(p_lo_slope_r >>> FRAC_BITS));
      lbias = sat32(66'(p_lo_icp_r >>> FRAC_BITS));
    end
    if (!uv_r[VAL_W-1]) begin
      uterm = sat32(66'(p_up_slope_r >>> FRAC_BITS));
      ubias = sat32(66'(p_up_icp_r >>> FRAC_BITS));
    end else begin
      uterm = rd_ls ? uv_r : '0;
      ubias = '0;
    end
    acc_lo = bias_rd_vld_r ? bias_rd_r[VAL_W-1:0] : '0;
    acc_up = bias_rd_vld_r ? bias_rd_r[2*VAL_W-1:VAL_W] : '0;
    sum_lo = sat32(66'(acc_lo) + 66'(lbias));
    sum_up = sat32(66'(acc_up) + 66'(ubias));
    entry  = 18'(src_r * tcount_r) + 18'(tgt_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && (op_r == OP_RELAX) && nrn_ok) begin
      relax_mem[nrn_r[NAW-1:0]] <= {rx_ls, rx_us, rx_icp};
    end
    if (cmd.finish && tgt_ok) begin
      case (op_r)
        OP_PRESET: bias_mem[tgt_r[TAW-1:0]] <= {uv_r, lv_r};
        OP_SUBST:  bias_mem[tgt_r[TAW-1:0]] <= {sum_up, sum_lo};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_vld_r <= '0;
    end else if (cmd.finish && tgt_ok && (op_r == OP_PRESET || op_r == OP_SUBST)) begin
      bias_vld_r[tgt_r[TAW-1:0]] <= 1'b1;
    end
  end

  // result word, fields without meaning for the op stay zero
  logic signed [VAL_W-1:0] clo_nxt, cup_nxt, icp_nxt, lterm_nxt, uterm_nxt;
  logic signed [VAL_W-1:0] lsum_nxt, usum_nxt;
  logic [SLOPE_W-1:0]      ls_nxt, us_nxt;
  logic [ENTRY_W-1:0]      entry_nxt;
  always_comb begin
    clo_nxt   = '0;
    cup_nxt   = '0;
    ls_nxt    = '0;
    us_nxt    = '0;
    icp_nxt   = '0;
    entry_nxt = '0;
    lterm_nxt = '0;
    uterm_nxt = '0;
    lsum_nxt  = '0;
    usum_nxt  = '0;
    case (op_r)
      OP_RELAX: begin
        clo_nxt = rx_clo;
        cup_nxt = rx_cup;
        ls_nxt  = rx_ls ? SLOPE_W'(ONE) : '0;
        us_nxt  = SLOPE_W'(rx_us);
        icp_nxt = rx_icp;
      end
      OP_PRESET: begin
        if (tgt_ok) begin
          lsum_nxt = lv_r;
          usum_nxt = uv_r;
        end
      end
      OP_SUBST: begin
        entry_nxt = entry[ENTRY_W-1:0];
        lterm_nxt = lterm;
        uterm_nxt = uterm;
        if (tgt_ok) begin
          lsum_nxt = sum_lo;
          usum_nxt = sum_up;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_concrete_lower  <= clo_nxt;
      out_concrete_upper  <= cup_nxt;
      out_lower_slope     <= ls_nxt;
      out_upper_slope     <= us_nxt;
      out_upper_intercept <= icp_nxt;
      out_entry_index     <= entry_nxt;
      out_lower_term      <= lterm_nxt;
      out_upper_term      <= uterm_nxt;
      out_lower_bias_sum  <= lsum_nxt;
      out_upper_bias_sum  <= usum_nxt;
    end
  end
endmodule

@@ rtl/relu_bound_relaxation.sv @@
// top level: relu bound relaxation and back-substitution unit
//
// fixed-point relu relaxation unit. a word with op relax classifies one
// neuron from its input bounds, stores its slopes and intercept and returns
// concrete bounds; preset loads a target's two bias accumulators; substitute
// reads a stored relaxation, forms the weight terms and adds the bias terms
// to the target's accumulators. one word is in flight at a time. preset,
// unused-op and relax words of an active or inactive neuron go from accept
// through dispatch to finish; substitute reads memory at accept and makes
// two passes through the pair of 32x33 multipliers before the accumulator
// write; relax of an unfixed neuron also runs the one-bit-per-cycle restoring
// divider for the upper slope. the result sits in an output register, so
// the next word is taken while the previous result waits. bias accumulators
// clear at reset through per-target valid bits, no clearing pass.
module relu_bound_relaxation import rbr_pkg::*; #(
  parameter int NEURONS   = 256,
  parameter int TARGETS   = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  rbr_in_if.sink            in_ch,
  rbr_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [TCNT_W-1:0] cfg_wdata
);
`include "assert_macros.svh"

  rbr_cmd_t  cmd;
  rbr_stat_t stat;

  // controller: handshakes, divider count, output slot
  rbr_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: operands, arithmetic, memories, result register
  rbr_dpath #(
    .NEURONS  (NEURONS),
    .TARGETS  (TARGETS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_op              (in_ch.op),
    .in_neuron          (in_ch.neuron),
    .in_source_neuron   (in_ch.source_neuron),
    .in_target          (in_ch.target),
    .in_lower_value     (in_ch.lower_value),
    .in_upper_value     (in_ch.upper_value),
    .out_concrete_lower (out_ch.concrete_lower),
    .out_concrete_upper (out_ch.concrete_upper),
    .out_lower_slope    (out_ch.lower_slope),
    .out_upper_slope    (out_ch.upper_slope),
    .out_upper_intercept(out_ch.upper_intercept),
    .out_entry_index    (out_ch.entry_index),
    .out_lower_term     (out_ch.lower_term),
    .out_upper_term     (out_ch.upper_term),
    .out_lower_bias_sum (out_ch.lower_bias_sum),
    .out_upper_bias_sum (out_ch.upper_bias_sum)
  );

  // a result is only loaded when the output slot is empty or draining
  `RBR_ASSERT_IMP(a_no_overwrite, cmd.finish, !out_ch.valid || out_ch.ready)
  // an accepted word makes the block busy on the next cycle
  `RBR_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // finishing a word always presents a result next cycle
  `RBR_ASSERT_NXT(a_result_after_finish, cmd.finish, out_ch.valid)
endmodule
